FILE: sv/lnwe_pkg.sv
// Package for the LCD nibble write engine: field widths, microcode format and program ROM.
package lnwe_pkg;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int ROW_W      = 3;
    localparam int COLUMN_W   = 5;
    localparam int NUMBER_W   = 16;
    localparam int NIBBLE_W   = 4;
    localparam int NUMBER_BITS_DEF = 16;

    // Decimal digits held for a 16-bit number
    localparam int DIGITS     = 5;
    localparam int DIG_CNT_W  = 3;
    localparam int BCD_W      = DIGITS * NIBBLE_W;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_CMD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CHAR   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CURSOR = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NUMBER = 2'd3;

    // Row base addresses
    localparam logic [BYTE_W-1:0] ROW1_BASE = 8'h80;
    localparam logic [BYTE_W-1:0] ROW2_BASE = 8'hC0;
    localparam logic [BYTE_W-1:0] ROW3_BASE = 8'h94;
    localparam logic [BYTE_W-1:0] ROW4_BASE = 8'hD4;

    // High nibble of an ASCII digit
    localparam logic [NIBBLE_W-1:0] ASCII_DIGIT_HI = 4'h3;

    // Microcode address
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] UPC_IDLE      = 4'd0;
    localparam logic [UPC_W-1:0] UPC_CMD       = 4'd1;
    localparam logic [UPC_W-1:0] UPC_CHAR_HI   = 4'd2;
    localparam logic [UPC_W-1:0] UPC_CHAR_LO   = 4'd3;
    localparam logic [UPC_W-1:0] UPC_CUR_HI    = 4'd4;
    localparam logic [UPC_W-1:0] UPC_CUR_LO    = 4'd5;
    localparam logic [UPC_W-1:0] UPC_CONV      = 4'd6;
    localparam logic [UPC_W-1:0] UPC_SKIP      = 4'd7;
    localparam logic [UPC_W-1:0] UPC_DIG_HI    = 4'd8;
    localparam logic [UPC_W-1:0] UPC_DIG_LO    = 4'd9;
    localparam logic [UPC_W-1:0] UPC_DIG_NEXT  = 4'd10;

    // Micro-op kinds
    localparam logic [2:0] UK_IDLE = 3'd0;  // accept a request, dispatch on opcode
    localparam logic [2:0] UK_EMIT = 3'd1;  // load one transfer when the output slot frees
    localparam logic [2:0] UK_CONV = 3'd2;  // one binary-to-BCD shift per cycle
    localparam logic [2:0] UK_SKIP = 3'd3;  // drop a leading zero digit
    localparam logic [2:0] UK_NEXT = 3'd4;  // advance to the next digit or finish

    // Nibble sources
    localparam logic [1:0] SRC_BHI = 2'd0;
    localparam logic [1:0] SRC_BLO = 2'd1;
    localparam logic [1:0] SRC_DHI = 2'd2;
    localparam logic [1:0] SRC_DLO = 2'd3;

    // Last-flag modes
    localparam logic [1:0] LAST_NO  = 2'd0;
    localparam logic [1:0] LAST_YES = 2'd1;
    localparam logic [1:0] LAST_DIG = 2'd2;

    typedef struct packed {
        logic [2:0]       kind;
        logic [1:0]       src;
        logic             rs;
        logic [1:0]       last_mode;
        logic [UPC_W-1:0] next;
    } t_uop;

    function automatic t_uop uop_rom(input logic [UPC_W-1:0] upc);
        t_uop u;
        u = '{kind: UK_IDLE, src: SRC_BLO, rs: 1'b0, last_mode: LAST_NO, next: UPC_IDLE};
        unique case (upc)
            UPC_IDLE:     u = '{UK_IDLE, SRC_BLO, 1'b0, LAST_NO,  UPC_IDLE};
            UPC_CMD:      u = '{UK_EMIT, SRC_BLO, 1'b0, LAST_YES, UPC_IDLE};
            UPC_CHAR_HI:  u = '{UK_EMIT, SRC_BHI, 1'b1, LAST_NO,  UPC_CHAR_LO};
            UPC_CHAR_LO:  u = '{UK_EMIT, SRC_BLO, 1'b1, LAST_YES, UPC_IDLE};
            UPC_CUR_HI:   u = '{UK_EMIT, SRC_BHI, 1'b0, LAST_NO,  UPC_CUR_LO};
            UPC_CUR_LO:   u = '{UK_EMIT, SRC_BLO, 1'b0, LAST_YES, UPC_IDLE};
            UPC_CONV:     u = '{UK_CONV, SRC_BLO, 1'b0, LAST_NO,  UPC_SKIP};
            UPC_SKIP:     u = '{UK_SKIP, SRC_BLO, 1'b0, LAST_NO,  UPC_DIG_HI};
            UPC_DIG_HI:   u = '{UK_EMIT, SRC_DHI, 1'b1, LAST_NO,  UPC_DIG_LO};
            UPC_DIG_LO:   u = '{UK_EMIT, SRC_DLO, 1'b1, LAST_DIG, UPC_DIG_NEXT};
            UPC_DIG_NEXT: u = '{UK_NEXT, SRC_BLO, 1'b0, LAST_NO,  UPC_DIG_HI};
            default:      u = '{UK_IDLE, SRC_BLO, 1'b0, LAST_NO,  UPC_IDLE};
        endcase
        return u;
    endfunction

endpackage

FILE: sv/lnwe_if.sv
// Handshake interfaces for requests and nibble transfers.
interface lnwe_req_if;
    logic                                valid;
    logic                                ready;
    logic [lnwe_pkg::OPCODE_W-1:0]       opcode;
    logic [lnwe_pkg::BYTE_W-1:0]         byte_value;
    logic [lnwe_pkg::ROW_W-1:0]          row;
    logic [lnwe_pkg::COLUMN_W-1:0]       column;
    logic [lnwe_pkg::NUMBER_W-1:0]       number;

    modport source (output valid, opcode, byte_value, row, column, number, input ready);
    modport sink   (input valid, opcode, byte_value, row, column, number, output ready);
endinterface

interface lnwe_xfer_if;
    logic                                valid;
    logic                                ready;
    logic                                reg_select;
    logic [lnwe_pkg::NIBBLE_W-1:0]       nibble;
    logic                                last;

    modport source (output valid, reg_select, nibble, last, input ready);
    modport sink   (input valid, reg_select, nibble, last, output ready);
endinterface

FILE: sv/lcd_nibble_write_engine.sv
// Top level of the LCD nibble write engine: microcoded sequencer and its datapath.
//
// Turns each request item into a run of 4-bit transfers for a character LCD in
// 4-bit mode, each with its register-select bit and a last flag on the final one.
// A command nibble gives one transfer, a character two, a cursor set two (rows
// 1..4 only, other rows give nothing), and a number two per decimal digit with
// leading zeros dropped. A small program ROM steps the work one micro-op per
// cycle, holding on a transfer step until the output register is free; one
// item is in work at a time and a new request is taken only when the
// sequencer is back at its idle step. A number is converted one bit per cycle
// through the binary-to-BCD shifter, capped at 16 bits. A waiting result sits
// in the output register while the sequencer goes on.
module lcd_nibble_write_engine #(
    parameter int NUMBER_BITS = lnwe_pkg::NUMBER_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lnwe_req_if.sink      i_req,
    lnwe_xfer_if.source   o_xfer
);

    // Width of the number actually converted
    localparam int NumW = (NUMBER_BITS < lnwe_pkg::NUMBER_W) ? NUMBER_BITS : lnwe_pkg::NUMBER_W;
    localparam int CntW = $clog2(NumW + 1);
    localparam int BcdW = lnwe_pkg::BCD_W;
    localparam int NibW = lnwe_pkg::NIBBLE_W;

    // Sequencer state
    logic [lnwe_pkg::UPC_W-1:0]     r_upc, n_upc;
    lnwe_pkg::t_uop                 uop;

    // Datapath registers
    logic [lnwe_pkg::BYTE_W-1:0]    r_byte, n_byte;
    logic [NumW-1:0]                r_bin, n_bin;
    logic [BcdW-1:0]                r_bcd, n_bcd;
    logic [CntW-1:0]                r_cnt, n_cnt;
    logic [lnwe_pkg::DIG_CNT_W-1:0] r_dig, n_dig;

    // Output register
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_rs, n_out_rs;
    logic [NibW-1:0]                r_out_nib, n_out_nib;
    logic                           r_out_last, n_out_last;

    logic                           req_fire;
    logic                           slot_free;
    logic                           row_ok;
    logic [lnwe_pkg::BYTE_W-1:0]    row_base;
    logic [lnwe_pkg::BYTE_W-1:0]    cur_addr;
    logic [BcdW-1:0]                bcd_adj;
    logic [NibW-1:0]                top_dig;
    logic [NibW-1:0]                src_nib;
    logic                           src_last;

    assign uop       = lnwe_pkg::uop_rom(r_upc);
    assign i_req.ready = (uop.kind == lnwe_pkg::UK_IDLE);
    assign req_fire  = i_req.valid && i_req.ready;
    assign slot_free = !r_out_valid || o_xfer.ready;
    assign top_dig   = r_bcd[BcdW-1 -: NibW];

    assign o_xfer.valid      = r_out_valid;
    assign o_xfer.reg_select = r_out_rs;
    assign o_xfer.nibble     = r_out_nib;
    assign o_xfer.last       = r_out_last;

    // Row base lookup; rows outside 1..4 emit nothing
    always_comb begin
        row_ok   = 1'b1;
        row_base = lnwe_pkg::ROW1_BASE;
        case (i_req.row)
            3'd1:    row_base = lnwe_pkg::ROW1_BASE;
            3'd2:    row_base = lnwe_pkg::ROW2_BASE;
            3'd3:    row_base = lnwe_pkg::ROW3_BASE;
            3'd4:    row_base = lnwe_pkg::ROW4_BASE;
            default: row_ok = 1'b0;
        endcase
    end

    // Base plus column minus one, wrapping in 8 bits
    assign cur_addr = row_base + {{(lnwe_pkg::BYTE_W - lnwe_pkg::COLUMN_W){1'b0}}, i_req.column}
                      + {lnwe_pkg::BYTE_W{1'b1}};

    // Add 3 to each BCD digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < lnwe_pkg::DIGITS; d++) begin
            if (r_bcd[d*NibW +: NibW] >= 4'd5) begin
                bcd_adj[d*NibW +: NibW] = r_bcd[d*NibW +: NibW] + 4'd3;
            end else begin
                bcd_adj[d*NibW +: NibW] = r_bcd[d*NibW +: NibW];
            end
        end
    end

    // Nibble source select
    always_comb begin
        case (uop.src)
            lnwe_pkg::SRC_BHI: src_nib = r_byte[lnwe_pkg::BYTE_W-1 -: NibW];
            lnwe_pkg::SRC_BLO: src_nib = r_byte[NibW-1:0];
            lnwe_pkg::SRC_DHI: src_nib = lnwe_pkg::ASCII_DIGIT_HI;
            default:           src_nib = top_dig;
        endcase
        case (uop.last_mode)
            lnwe_pkg::LAST_YES: src_last = 1'b1;
            lnwe_pkg::LAST_DIG: src_last = (r_dig == lnwe_pkg::DIG_CNT_W'(1));
            default:            src_last = 1'b0;
        endcase
    end

    // Micro-op execution
    always_comb begin
        n_upc       = r_upc;
        n_byte      = r_byte;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !o_xfer.ready;
        n_out_rs    = r_out_rs;
        n_out_nib   = r_out_nib;
        n_out_last  = r_out_last;

        unique case (uop.kind)
            lnwe_pkg::UK_IDLE: begin
                if (req_fire) begin
                    n_byte = i_req.byte_value;
                    n_bin  = i_req.number[NumW-1:0];
                    n_bcd  = '0;
                    n_cnt  = CntW'(NumW);
                    n_dig  = lnwe_pkg::DIG_CNT_W'(lnwe_pkg::DIGITS);
                    case (i_req.opcode)
                        lnwe_pkg::OP_CMD:  n_upc = lnwe_pkg::UPC_CMD;
                        lnwe_pkg::OP_CHAR: n_upc = lnwe_pkg::UPC_CHAR_HI;
                        lnwe_pkg::OP_CURSOR: begin
                            n_byte = cur_addr;
                            n_upc  = row_ok ? lnwe_pkg::UPC_CUR_HI : lnwe_pkg::UPC_IDLE;
                        end
                        default:           n_upc = lnwe_pkg::UPC_CONV;
                    endcase
                end
            end
            lnwe_pkg::UK_EMIT: begin
                // Hold until the output register frees
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_rs    = uop.rs;
                    n_out_nib   = src_nib;
                    n_out_last  = src_last;
                    n_upc       = uop.next;
                end
            end
            lnwe_pkg::UK_CONV: begin
                if (r_cnt != '0) begin
                    n_bcd = {bcd_adj[BcdW-2:0], r_bin[NumW-1]};
                    n_bin = r_bin << 1;
                    n_cnt = r_cnt - CntW'(1);
                end else begin
                    n_upc = uop.next;
                end
            end
            lnwe_pkg::UK_SKIP: begin
                // Drop leading zeros, keeping at least one digit
                if (top_dig == '0 && r_dig > lnwe_pkg::DIG_CNT_W'(1)) begin
                    n_bcd = r_bcd << NibW;
                    n_dig = r_dig - lnwe_pkg::DIG_CNT_W'(1);
                end else begin
                    n_upc = uop.next;
                end
            end
            lnwe_pkg::UK_NEXT: begin
                n_bcd = r_bcd << NibW;
                n_dig = r_dig - lnwe_pkg::DIG_CNT_W'(1);
                n_upc = (r_dig > lnwe_pkg::DIG_CNT_W'(1)) ? uop.next : lnwe_pkg::UPC_IDLE;
            end
            default: n_upc = lnwe_pkg::UPC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= lnwe_pkg::UPC_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_dig      <= n_dig;
        r_out_rs   <= n_out_rs;
        r_out_nib  <= n_out_nib;
        r_out_last <= n_out_last;
    end

endmodule
